@@ rtl/vste_pkg.sv @@
// Package for the voxel surface triangle emitter: grid size, field widths,
// face direction codes, the face corner table and the emit request type.
// Depends on nothing; every other file of the block depends on it.
package vste_pkg;

  // Grid edge in voxels and the widths that follow from it.
  localparam int GRID_EDGE = 64;
  localparam int COORD_W   = 6;
  localparam int CORNER_W  = 7;
  localparam int DIR_W     = 3;
  localparam int CELL_W    = $clog2(GRID_EDGE);
  localparam int EXT_W     = (COORD_W + 1 > CELL_W + 1) ? COORD_W + 1 : CELL_W + 1;
  localparam int ADDR_W    = 3 * CELL_W;
  localparam int DEPTH     = 1 << ADDR_W;

  // Centre voxel plus six neighbours are read for each query.
  localparam int NUM_FACES = 6;
  localparam int NUM_READS = NUM_FACES + 1;
  localparam int RDK_W     = $clog2(NUM_READS + 1);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_NEG_Z = 3'd0,
    DIR_POS_Z = 3'd1,
    DIR_NEG_X = 3'd2,
    DIR_POS_X = 3'd3,
    DIR_NEG_Y = 3'd4,
    DIR_POS_Y = 3'd5
  } dir_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  // One result request from the sequencer to the output stage.
  typedef struct packed {
    logic             tri_valid;
    logic             last;
    logic [DIR_W-1:0] dir;
    logic             half;
  } tri_req_t;

  // Corner offset {x, y, z} of corner idx (p0..p3) of face dir.
  function automatic logic [2:0] face_corner(input logic [DIR_W-1:0] dir,
                                             input logic [1:0] idx);
    logic [11:0] row;
    row = '0;
    case (dir)
      DIR_NEG_Z: row = {3'b010, 3'b110, 3'b100, 3'b000};
      DIR_POS_Z: row = {3'b001, 3'b101, 3'b111, 3'b011};
      DIR_NEG_X: row = {3'b001, 3'b011, 3'b010, 3'b000};
      DIR_POS_X: row = {3'b100, 3'b110, 3'b111, 3'b101};
      DIR_NEG_Y: row = {3'b000, 3'b100, 3'b101, 3'b001};
      DIR_POS_Y: row = {3'b011, 3'b111, 3'b110, 3'b010};
      default:   row = '0;
    endcase
    case (idx)
      2'd0:    return row[11:9];
      2'd1:    return row[8:6];
      2'd2:    return row[5:3];
      default: return row[2:0];
    endcase
  endfunction

endpackage

@@ rtl/vste_if.sv @@
// Valid/ready channel interfaces for the voxel surface triangle emitter:
// the input item channel and the result channel. Depends on vste_pkg.
interface vste_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [vste_pkg::COORD_W-1:0] pos_x;
  logic [vste_pkg::COORD_W-1:0] pos_y;
  logic [vste_pkg::COORD_W-1:0] pos_z;
  logic                        occupied;

  modport source (output valid, action, pos_x, pos_y, pos_z, occupied, input ready);
  modport sink   (input valid, action, pos_x, pos_y, pos_z, occupied, output ready);
endinterface

interface vste_res_if;
  logic                         valid;
  logic                         ready;
  logic                         tri_valid;
  logic                         last;
  logic [vste_pkg::DIR_W-1:0]    face_dir;
  logic [vste_pkg::CORNER_W-1:0] corner_a_x;
  logic [vste_pkg::CORNER_W-1:0] corner_a_y;
  logic [vste_pkg::CORNER_W-1:0] corner_a_z;
  logic [vste_pkg::CORNER_W-1:0] corner_b_x;
  logic [vste_pkg::CORNER_W-1:0] corner_b_y;
  logic [vste_pkg::CORNER_W-1:0] corner_b_z;
  logic [vste_pkg::CORNER_W-1:0] corner_c_x;
  logic [vste_pkg::CORNER_W-1:0] corner_c_y;
  logic [vste_pkg::CORNER_W-1:0] corner_c_z;

  modport source (output valid, tri_valid, last, face_dir,
                  corner_a_x, corner_a_y, corner_a_z,
                  corner_b_x, corner_b_y, corner_b_z,
                  corner_c_x, corner_c_y, corner_c_z,
                  input ready);
  modport sink   (input valid, tri_valid, last, face_dir,
                  corner_a_x, corner_a_y, corner_a_z,
                  corner_b_x, corner_b_y, corner_b_z,
                  corner_c_x, corner_c_y, corner_c_z,
                  output ready);
endinterface

@@ rtl/vste_tri_gen.sv @@
// Output stage of the voxel surface triangle emitter: turns a face request
// into one triangle with absolute corners, or into a result with no triangle,
// and holds it in the result register. Depends on vste_pkg and vste_if.
module vste_tri_gen (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  vste_pkg::tri_req_t           req_i,
  input  logic [vste_pkg::COORD_W-1:0] pos_x_i,
  input  logic [vste_pkg::COORD_W-1:0] pos_y_i,
  input  logic [vste_pkg::COORD_W-1:0] pos_z_i,
  vste_res_if.source                   res_o
);
  import vste_pkg::*;

  logic                valid_q;
  logic                tri_valid_q, last_q;
  logic [DIR_W-1:0]    dir_q;
  logic [CORNER_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;

  logic [1:0]          idx_a, idx_b, idx_c;
  logic [2:0]          off_a, off_b, off_c;
  logic [CORNER_W-1:0] px, py, pz;
  logic                load;

  // A new request may enter when the register is empty or being emptied.
  assign req_ready_o = !valid_q || res_o.ready;
  assign load        = req_valid_i && req_ready_o;

  // The first triangle of a face uses p0, p1, p2 and the second p2, p3, p0.
  always_comb begin
    if (req_i.half) begin
      idx_a = 2'd2;
      idx_b = 2'd3;
      idx_c = 2'd0;
    end else begin
      idx_a = 2'd0;
      idx_b = 2'd1;
      idx_c = 2'd2;
    end
    off_a = face_corner(req_i.dir, idx_a);
    off_b = face_corner(req_i.dir, idx_b);
    off_c = face_corner(req_i.dir, idx_c);
    px    = CORNER_W'(pos_x_i);
    py    = CORNER_W'(pos_y_i);
    pz    = CORNER_W'(pos_z_i);
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (res_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  // Result payload; a result without a triangle carries zeros.
  always_ff @(posedge clk_i) begin
    if (load) begin
      tri_valid_q <= req_i.tri_valid;
      last_q      <= req_i.last;
      if (req_i.tri_valid) begin
        dir_q <= req_i.dir;
        ax_q  <= px + CORNER_W'(off_a[2]);
        ay_q  <= py + CORNER_W'(off_a[1]);
        az_q  <= pz + CORNER_W'(off_a[0]);
        bx_q  <= px + CORNER_W'(off_b[2]);
        by_q  <= py + CORNER_W'(off_b[1]);
        bz_q  <= pz + CORNER_W'(off_b[0]);
        cx_q  <= px + CORNER_W'(off_c[2]);
        cy_q  <= py + CORNER_W'(off_c[1]);
        cz_q  <= pz + CORNER_W'(off_c[0]);
      end else begin
        dir_q <= '0;
        ax_q  <= '0;
        ay_q  <= '0;
        az_q  <= '0;
        bx_q  <= '0;
        by_q  <= '0;
        bz_q  <= '0;
        cx_q  <= '0;
        cy_q  <= '0;
        cz_q  <= '0;
      end
    end
  end

  assign res_o.valid      = valid_q;
  assign res_o.tri_valid  = tri_valid_q;
  assign res_o.last       = last_q;
  assign res_o.face_dir   = dir_q;
  assign res_o.corner_a_x = ax_q;
  assign res_o.corner_a_y = ay_q;
  assign res_o.corner_a_z = az_q;
  assign res_o.corner_b_x = bx_q;
  assign res_o.corner_b_y = by_q;
  assign res_o.corner_b_z = bz_q;
  assign res_o.corner_c_x = cx_q;
  assign res_o.corner_c_y = cy_q;
  assign res_o.corner_c_z = cz_q;

endmodule

@@ rtl/voxel_surface_triangle_emitter_core.sv @@
// Top level of the voxel surface triangle emitter: voxel memory, query
// sequencer and output stage. Depends on vste_pkg, vste_if and vste_tri_gen.
//
// The block holds a GRID_EDGE^3 grid of one-bit voxels in a synchronous
// memory with a write port, a read port and no reset; every voxel must be
// written before it is queried. A write transfer stores one voxel in the
// cycle it is accepted, so writes stream at one per cycle. A query reads the
// centre voxel and its six neighbours through the one memory read port, one
// read per cycle, and collects the last read bit. It then emits its
// results at one per cycle while the result sink does not stall: two
// triangles for every open face, or a single result without a triangle when
// the voxel is empty or enclosed. The next item is taken once the last result
// has entered the output register.
module voxel_surface_triangle_emitter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  vste_in_if.sink     in_i,
  vste_res_if.source  res_o
);
  import vste_pkg::*;

  state_e                  state_q, state_d;
  logic [COORD_W-1:0]      pos_x_q, pos_y_q, pos_z_q;
  logic [RDK_W-1:0]        rd_k_q, rd_k_d;
  logic                    rd_ok_q;
  logic [NUM_READS-1:0]    occ_q, occ_d;
  logic [NUM_FACES-1:0]    faces_q, faces_d;
  logic                    empty_q, empty_d;
  logic                    half_q, half_d;

  logic                    mem [DEPTH];
  logic                    rdata_q;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic                    rd_en, rd_ok;

  logic [EXT_W-1:0]        ex, ey, ez;
  logic                    step_ok;
  logic [DIR_W-1:0]        rd_dir;
  logic [EXT_W-1:0]        wx, wy, wz;

  logic [DIR_W-1:0]        cur_dir;
  logic [NUM_FACES-1:0]    faces_left;
  tri_req_t                req;
  logic                    req_valid, req_ready, req_done;

  // Voxel write address and range check for the incoming item.
  always_comb begin
    wx      = EXT_W'(in_i.pos_x);
    wy      = EXT_W'(in_i.pos_y);
    wz      = EXT_W'(in_i.pos_z);
    wr_addr = {wz[CELL_W-1:0], wx[CELL_W-1:0], wy[CELL_W-1:0]};
    wr_en   = (state_q == ST_IDLE) && in_i.valid && (in_i.action == ACT_WRITE) &&
              (wx < EXT_W'(GRID_EDGE)) && (wy < EXT_W'(GRID_EDGE)) &&
              (wz < EXT_W'(GRID_EDGE));
  end

  assign in_i.ready = (state_q == ST_IDLE);

  // Read address: the centre first, then the neighbour in each face direction.
  always_comb begin
    ex      = EXT_W'(pos_x_q);
    ey      = EXT_W'(pos_y_q);
    ez      = EXT_W'(pos_z_q);
    step_ok = 1'b1;
    rd_dir  = DIR_W'(rd_k_q - RDK_W'(1));
    if (rd_k_q != '0) begin
      case (rd_dir)
        DIR_NEG_Z: begin
          step_ok = (ez != '0);
          ez      = ez - EXT_W'(1);
        end
        DIR_POS_Z: ez = ez + EXT_W'(1);
        DIR_NEG_X: begin
          step_ok = (ex != '0);
          ex      = ex - EXT_W'(1);
        end
        DIR_POS_X: ex = ex + EXT_W'(1);
        DIR_NEG_Y: begin
          step_ok = (ey != '0);
          ey      = ey - EXT_W'(1);
        end
        DIR_POS_Y: ey = ey + EXT_W'(1);
        default:   step_ok = 1'b0;
      endcase
    end
    rd_ok   = step_ok && (ex < EXT_W'(GRID_EDGE)) && (ey < EXT_W'(GRID_EDGE)) &&
              (ez < EXT_W'(GRID_EDGE));
    rd_addr = {ez[CELL_W-1:0], ex[CELL_W-1:0], ey[CELL_W-1:0]};
    rd_en   = (state_q == ST_READ) && (rd_k_q < RDK_W'(NUM_READS));
  end

  // Voxel memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_i.occupied;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Lowest open face still to emit.
  always_comb begin
    cur_dir = '0;
    for (int i = NUM_FACES - 1; i >= 0; i--) begin
      if (faces_q[i]) begin
        cur_dir = DIR_W'(i);
      end
    end
    faces_left = faces_q & ~(NUM_FACES'(1) << cur_dir);
  end

  // Request to the output stage.
  always_comb begin
    req.tri_valid = !empty_q;
    req.last      = empty_q || (half_q && (faces_left == '0));
    req.dir       = cur_dir;
    req.half      = half_q;
    req_valid     = (state_q == ST_EMIT);
    req_done      = req_valid && req_ready;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && (in_i.action == ACT_QUERY)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_k_q == RDK_W'(NUM_READS)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (req_done && req.last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer datapath: read counter, gathered voxel bits, face mask.
  always_comb begin
    rd_k_d  = rd_k_q;
    occ_d   = occ_q;
    faces_d = faces_q;
    empty_d = empty_q;
    half_d  = half_q;
    case (state_q)
      ST_IDLE: begin
        rd_k_d = '0;
        half_d = 1'b0;
      end
      ST_READ: begin
        rd_k_d = rd_k_q + RDK_W'(1);
        if (rd_k_q != '0) begin
          occ_d[rd_k_q - RDK_W'(1)] = rd_ok_q && rdata_q;
        end
        if (rd_k_q == RDK_W'(NUM_READS)) begin
          rd_k_d  = rd_k_q;
          faces_d = occ_d[0] ? ~occ_d[NUM_READS-1:1] : '0;
          empty_d = (faces_d == '0);
          half_d  = 1'b0;
        end
      end
      ST_EMIT: begin
        if (req_done && !empty_q) begin
          if (half_q) begin
            faces_d = faces_left;
            half_d  = 1'b0;
          end else begin
            half_d  = 1'b1;
          end
        end
      end
      default: begin
        rd_k_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rd_k_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_k_q  <= rd_k_d;
      half_q  <= half_d;
    end
  end

  // Query payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      pos_x_q <= in_i.pos_x;
      pos_y_q <= in_i.pos_y;
      pos_z_q <= in_i.pos_z;
    end
    rd_ok_q <= rd_ok;
    occ_q   <= occ_d;
    faces_q <= faces_d;
    empty_q <= empty_d;
  end

  vste_tri_gen u_tri_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .pos_x_i     (pos_x_q),
    .pos_y_i     (pos_y_q),
    .pos_z_i     (pos_z_q),
    .res_o       (res_o)
  );

endmodule

@@ test/voxel_surface_triangle_emitter_checker.sv @@
// Checker for the voxel surface triangle emitter: watches the item and result
// channels, keeps its own voxel map and predicts the triangles of each query.
// Depends on vste_pkg and the channel interfaces in vste_if.
`timescale 1ns / 100ps

module voxel_surface_triangle_emitter_checker (
  input  logic clk_i,
  input  logic rst_ni,
  vste_in_if   in_i,
  vste_res_if  res_i,
  output int   mismatch_count_o,
  output int   pending_o
);
  import vste_pkg::*;

  // One predicted result, field for field as it leaves the block.
  typedef struct packed {
    logic                tri_valid;
    logic                last;
    logic [DIR_W-1:0]    face_dir;
    logic [CORNER_W-1:0] corner_a_x;
    logic [CORNER_W-1:0] corner_a_y;
    logic [CORNER_W-1:0] corner_a_z;
    logic [CORNER_W-1:0] corner_b_x;
    logic [CORNER_W-1:0] corner_b_y;
    logic [CORNER_W-1:0] corner_b_z;
    logic [CORNER_W-1:0] corner_c_x;
    logic [CORNER_W-1:0] corner_c_y;
    logic [CORNER_W-1:0] corner_c_z;
  } face_tri_t;

  bit        voxel_map [DEPTH];
  face_tri_t tri_queue [$];
  face_tri_t want_tri;
  int        mismatches    = 0;
  int        expected_left = 0;
  int        results_seen  = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = expected_left;

  // Prints one line per mismatch and counts every one.
  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s = %0d, predicted %0d",
                                results_seen, name, got, want));
    end
  endtask

  function automatic int cell_index(input int x, input int y, input int z);
    return (z * GRID_EDGE + x) * GRID_EDGE + y;
  endfunction

  // A neighbour outside the grid reads as empty.
  function automatic bit occupied_at(input int x, input int y, input int z);
    if (x < 0 || x >= GRID_EDGE || y < 0 || y >= GRID_EDGE || z < 0 || z >= GRID_EDGE) begin
      return 1'b0;
    end
    return voxel_map[cell_index(x, y, z)];
  endfunction

  function automatic void neighbour_step(input dir_e d, output int dx, output int dy,
                                         output int dz);
    dx = 0;
    dy = 0;
    dz = 0;
    case (d)
      DIR_NEG_Z: dz = -1;
      DIR_POS_Z: dz = 1;
      DIR_NEG_X: dx = -1;
      DIR_POS_X: dx = 1;
      DIR_NEG_Y: dy = -1;
      default:   dy = 1;
    endcase
  endfunction

  // Corner k of the face in direction d as an {x, y, z} offset from the voxel.
  function automatic logic [2:0] face_point(input dir_e d, input int k);
    logic [2:0] pts [4];
    case (d)
      DIR_NEG_Z: pts = '{3'b010, 3'b110, 3'b100, 3'b000};
      DIR_POS_Z: pts = '{3'b001, 3'b101, 3'b111, 3'b011};
      DIR_NEG_X: pts = '{3'b001, 3'b011, 3'b010, 3'b000};
      DIR_POS_X: pts = '{3'b100, 3'b110, 3'b111, 3'b101};
      DIR_NEG_Y: pts = '{3'b000, 3'b100, 3'b101, 3'b001};
      default:   pts = '{3'b011, 3'b111, 3'b110, 3'b010};
    endcase
    return pts[k];
  endfunction

  function automatic face_tri_t make_triangle(input dir_e d, input int x, input int y,
                                              input int z, input int ka, input int kb,
                                              input int kc);
    face_tri_t  t;
    logic [2:0] pa;
    logic [2:0] pb;
    logic [2:0] pc;
    pa = face_point(d, ka);
    pb = face_point(d, kb);
    pc = face_point(d, kc);
    t            = '0;
    t.tri_valid  = 1'b1;
    t.face_dir   = d;
    t.corner_a_x = CORNER_W'(x + int'(pa[2]));
    t.corner_a_y = CORNER_W'(y + int'(pa[1]));
    t.corner_a_z = CORNER_W'(z + int'(pa[0]));
    t.corner_b_x = CORNER_W'(x + int'(pb[2]));
    t.corner_b_y = CORNER_W'(y + int'(pb[1]));
    t.corner_b_z = CORNER_W'(z + int'(pb[0]));
    t.corner_c_x = CORNER_W'(x + int'(pc[2]));
    t.corner_c_y = CORNER_W'(y + int'(pc[1]));
    t.corner_c_z = CORNER_W'(z + int'(pc[0]));
    return t;
  endfunction

  // Two triangles for every open face of a set voxel, in face order; an empty
  // or enclosed voxel gives one result with no triangle. The final one is last.
  function automatic void predict_query(input int x, input int y, input int z);
    face_tri_t batch [$];
    face_tri_t t;
    dir_e      d;
    int        dx;
    int        dy;
    int        dz;
    if (occupied_at(x, y, z)) begin
      for (int i = 0; i < NUM_FACES; i++) begin
        d = dir_e'(i);
        neighbour_step(d, dx, dy, dz);
        if (!occupied_at(x + dx, y + dy, z + dz)) begin
          batch.push_back(make_triangle(d, x, y, z, 0, 1, 2));
          batch.push_back(make_triangle(d, x, y, z, 2, 3, 0));
        end
      end
    end
    if (batch.size() == 0) begin
      batch.push_back('0);
    end
    foreach (batch[i]) begin
      t      = batch[i];
      t.last = (i == batch.size() - 1);
      tri_queue.push_back(t);
    end
  endfunction

  // Results are compared before the item of the same edge is predicted, so a
  // query can never match a result that left in the cycle it was taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_i.valid && res_i.ready) begin
        if (tri_queue.size() == 0) begin
          report_mismatch($sformatf("result %0d transferred with nothing predicted",
                                    results_seen));
        end else begin
          want_tri = tri_queue.pop_front();
          compare_field("tri_valid", int'(res_i.tri_valid), int'(want_tri.tri_valid));
          compare_field("last", int'(res_i.last), int'(want_tri.last));
          compare_field("face_dir", int'(res_i.face_dir), int'(want_tri.face_dir));
          compare_field("corner_a_x", int'(res_i.corner_a_x), int'(want_tri.corner_a_x));
          compare_field("corner_a_y", int'(res_i.corner_a_y), int'(want_tri.corner_a_y));
          compare_field("corner_a_z", int'(res_i.corner_a_z), int'(want_tri.corner_a_z));
          compare_field("corner_b_x", int'(res_i.corner_b_x), int'(want_tri.corner_b_x));
          compare_field("corner_b_y", int'(res_i.corner_b_y), int'(want_tri.corner_b_y));
          compare_field("corner_b_z", int'(res_i.corner_b_z), int'(want_tri.corner_b_z));
          compare_field("corner_c_x", int'(res_i.corner_c_x), int'(want_tri.corner_c_x));
          compare_field("corner_c_y", int'(res_i.corner_c_y), int'(want_tri.corner_c_y));
          compare_field("corner_c_z", int'(res_i.corner_c_z), int'(want_tri.corner_c_z));
        end
        results_seen++;
      end
      if (in_i.valid && in_i.ready) begin
        if (action_e'(in_i.action) == ACT_WRITE) begin
          if (int'(in_i.pos_x) < GRID_EDGE && int'(in_i.pos_y) < GRID_EDGE &&
              int'(in_i.pos_z) < GRID_EDGE) begin
            voxel_map[cell_index(int'(in_i.pos_x), int'(in_i.pos_y), int'(in_i.pos_z))] =
              in_i.occupied;
          end
        end else begin
          predict_query(int'(in_i.pos_x), int'(in_i.pos_y), int'(in_i.pos_z));
        end
      end
      expected_left <= tri_queue.size();
    end
  end

endmodule

@@ test/voxel_surface_triangle_emitter_core_test.sv @@
// Testbench top for the voxel surface triangle emitter: clock, reset, item
// stimulus, result back-pressure, stall watchdog and the final verdict.
// Depends on vste_pkg, vste_if, the block and its checker.
`timescale 1ns / 100ps

module voxel_surface_triangle_emitter_core_test;
  import vste_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TOTAL  = 370;
  localparam int SETTLE      = 30;

  logic clk_i = 1'b0;
  logic rst_ni;

  vste_in_if  in_if ();
  vste_res_if res_if ();

  int mismatch_count;
  int results_pending;
  int src_idle_pct = 18;
  int snk_idle_pct = 58;
  int items_sent   = 0;

  // Voxels written so far; a query only names a voxel whose in-grid
  // neighbourhood is fully written, as the memory has no reset.
  bit                voxel_written [DEPTH];
  logic [ADDR_W-1:0] query_spots [$];

  voxel_surface_triangle_emitter_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  voxel_surface_triangle_emitter_checker face_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_i             (in_if),
    .res_i            (res_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] spot_addr(input int x, input int y, input int z);
    return {CELL_W'(z), CELL_W'(x), CELL_W'(y)};
  endfunction

  // Coordinates lean towards the grid edges and a small hot region, so that
  // neighbourhoods are shared and boundary faces come up often.
  function automatic int pick_coord(input int hot);
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      return (r < 5) ? 0 : (r < 10) ? 1 : (r < 15) ? GRID_EDGE - 2 : GRID_EDGE - 1;
    end
    if (r < 60) begin
      return hot + int'($urandom_range(3));
    end
    return int'($urandom_range(GRID_EDGE - 1));
  endfunction

  // One item transfer, after a random number of idle cycles.
  task automatic send_item(input action_e act, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                           input logic occ);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.pos_x    <= x;
    in_if.pos_y    <= y;
    in_if.pos_z    <= z;
    in_if.occupied <= occ;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (act == ACT_WRITE) begin
      voxel_written[spot_addr(int'(x), int'(y), int'(z))] = 1'b1;
    end else begin
      query_spots.push_back(spot_addr(int'(x), int'(y), int'(z)));
    end
  endtask

  // Hold the item channel idle until every predicted result has transferred.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
  endtask

  // Result back-pressure, redrawn every cycle.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int                phase_end [3];
    int                hot;
    int                cx;
    int                cy;
    int                cz;
    int                nx;
    int                ny;
    int                nz;
    logic [ADDR_W-1:0] spot;

    rst_ni         <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.action   <= ACT_WRITE;
    in_if.pos_x    <= '0;
    in_if.pos_y    <= '0;
    in_if.pos_z    <= '0;
    in_if.occupied <= 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Origin corner: three faces on the grid boundary, three open to empty voxels.
    send_item(ACT_WRITE, 6'd0, 6'd0, 6'd0, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd0, 6'd0, 1'b0);
    send_item(ACT_WRITE, 6'd0, 6'd1, 6'd0, 1'b0);
    send_item(ACT_WRITE, 6'd0, 6'd0, 6'd1, 1'b0);
    send_item(ACT_QUERY, 6'd0, 6'd0, 6'd0, 1'b0);

    // Far corner, where corner coordinates reach their largest value, 64.
    send_item(ACT_WRITE, 6'd63, 6'd63, 6'd63, 1'b1);
    send_item(ACT_WRITE, 6'd62, 6'd63, 6'd63, 1'b0);
    send_item(ACT_WRITE, 6'd63, 6'd62, 6'd63, 1'b0);
    send_item(ACT_WRITE, 6'd63, 6'd63, 6'd62, 1'b0);
    send_item(ACT_QUERY, 6'd63, 6'd63, 6'd63, 1'b1);

    // Fully enclosed voxel, then the same voxel cleared.
    send_item(ACT_WRITE, 6'd1, 6'd1, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd0, 6'd1, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd2, 6'd1, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd0, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd2, 6'd1, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd1, 6'd0, 1'b1);
    send_item(ACT_WRITE, 6'd1, 6'd1, 6'd2, 1'b1);
    send_item(ACT_QUERY, 6'd1, 6'd1, 6'd1, 1'b0);
    send_item(ACT_WRITE, 6'd1, 6'd1, 6'd1, 1'b0);
    send_item(ACT_QUERY, 6'd1, 6'd1, 6'd1, 1'b1);

    phase_end[0] = items_sent + (ITEM_TOTAL - items_sent) / 3;
    phase_end[1] = items_sent + 2 * (ITEM_TOTAL - items_sent) / 3;
    phase_end[2] = ITEM_TOTAL;

    for (int ph = 0; ph < 3; ph++) begin
      // Swap the idling sides between phases, and finish with none at all.
      if (ph == 1) begin
        src_idle_pct = 58;
        snk_idle_pct = 18;
      end else if (ph == 2) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (ph != 0) begin
        wait_for_drain();
      end
      hot = int'($urandom_range(GRID_EDGE - 4));

      while (items_sent < phase_end[ph]) begin
        if ($urandom_range(99) < 85) begin
          // Fill in or refresh the centre and its neighbours, then query it.
          cx = pick_coord(hot);
          cy = pick_coord(hot);
          cz = pick_coord(hot);
          for (int k = 0; k < 7; k++) begin
            nx = cx;
            ny = cy;
            nz = cz;
            case (k)
              1:       nz = cz - 1;
              2:       nz = cz + 1;
              3:       nx = cx - 1;
              4:       nx = cx + 1;
              5:       ny = cy - 1;
              6:       ny = cy + 1;
              default: ;
            endcase
            if (nx >= 0 && nx < GRID_EDGE && ny >= 0 && ny < GRID_EDGE &&
                nz >= 0 && nz < GRID_EDGE) begin
              if (!voxel_written[spot_addr(nx, ny, nz)] || $urandom_range(99) < 30) begin
                send_item(ACT_WRITE, COORD_W'(nx), COORD_W'(ny), COORD_W'(nz),
                          $urandom_range(99) < ((k == 0) ? 80 : 45));
              end
            end
          end
          send_item(ACT_QUERY, COORD_W'(cx), COORD_W'(cy), COORD_W'(cz),
                    1'($urandom_range(1)));
        end else if ($urandom_range(1) == 0 || query_spots.size() == 0) begin
          // Stray write anywhere in the grid, with no query after it.
          send_item(ACT_WRITE, COORD_W'($urandom_range(GRID_EDGE - 1)),
                    COORD_W'($urandom_range(GRID_EDGE - 1)),
                    COORD_W'($urandom_range(GRID_EDGE - 1)), 1'($urandom_range(1)));
        end else begin
          // Query again a voxel whose neighbourhood is known to be written.
          spot = query_spots[$urandom_range(query_spots.size() - 1)];
          send_item(ACT_QUERY, spot[2*CELL_W-1 -: CELL_W], spot[CELL_W-1:0],
                    spot[ADDR_W-1 -: CELL_W], 1'($urandom_range(1)));
        end
      end
    end

    wait_for_drain();
    repeat (SETTLE) @(negedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
